/* src/hes_pkg.sv */
// Shared types and constants for the 1-D heat equation stencil.
// No dependencies; used by hes_cell and heat_equation_stencil_1d.
package hes_pkg;

	// Sample and register widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned ALPHA_W  = 16;
	localparam int unsigned STEPS_W  = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS = 1'b1;

	// Saturation bounds of a Q1.14 sample
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// Control to every cell of the row
	typedef struct packed {
		logic shift;  // take the right neighbor's value
		logic step;   // apply one explicit time step
	} cell_ctrl_t;

endpackage

/* src/hes_cell.sv */
// One grid point of the stencil row: holds a sample, shifts it or updates it.
// Depends on hes_pkg for widths, bounds and the control struct.
module hes_cell (
	input  logic                                  clk,
	input  hes_pkg::cell_ctrl_t                   ctrl,
	input  logic        [hes_pkg::ALPHA_W-1:0]    alpha,
	input  logic signed [hes_pkg::SAMPLE_W-1:0]   left,
	input  logic signed [hes_pkg::SAMPLE_W-1:0]   right,
	output logic signed [hes_pkg::SAMPLE_W-1:0]   value
);

	logic signed [hes_pkg::SAMPLE_W-1:0] value_q;
	logic signed [18:0] diff;
	logic signed [35:0] prod;
	logic signed [35:0] prod_rnd;
	logic signed [19:0] delta;
	logic signed [20:0] sum;
	logic signed [hes_pkg::SAMPLE_W-1:0] next_val;

	// u' = u + round(alpha*(l + r - 2u) / 2^16), then saturate
	always_comb begin
		diff = 19'(left) + 19'(right) - (19'(value_q) <<< 1);
		prod = $signed({1'b0, alpha}) * diff;
		prod_rnd = prod + 36'sd32768;
		delta = prod_rnd[35:16];
		sum = 21'(value_q) + 21'(delta);
		if (sum > 21'(hes_pkg::SAMPLE_MAX)) begin
			next_val = hes_pkg::SAMPLE_MAX;
		end else if (sum < 21'(hes_pkg::SAMPLE_MIN)) begin
			next_val = hes_pkg::SAMPLE_MIN;
		end else begin
			next_val = sum[hes_pkg::SAMPLE_W-1:0];
		end
	end

	// Shift has priority; step only runs while the row is not moving
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right;
		end else if (ctrl.step) begin
			value_q <= next_val;
		end
	end

	assign value = value_q;

endmodule

/* src/heat_equation_stencil_1d.sv */
// Explicit FTCS 1-D heat equation: a row of GRID_POINTS cells, one per point.
// Load takes GRID_POINTS input beats; run applies step_count time steps, one per
// cycle, then enters emit; emit gives GRID_POINTS beats from cell 0, one per cycle
// while m_tready is high. Reset restores register defaults and the sequencer;
// grid data is unset.
module heat_equation_stencil_1d #(
	parameter int unsigned GRID_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [hes_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hes_pkg::CFG_W-1:0]           cfg_data,
	// input samples
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,   // [15:0] sample
	// output values
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,   // [15:0] value
	output logic                                m_tlast    // last_value
);

	localparam int unsigned IDX_W = $clog2(GRID_POINTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_POINTS - 1);

	hes_pkg::state_t state_q;
	logic [hes_pkg::ALPHA_W-1:0] alpha_q;
	logic [hes_pkg::STEPS_W-1:0] step_count_q;
	logic [hes_pkg::ALPHA_W-1:0] run_alpha_q;
	logic [hes_pkg::STEPS_W-1:0] run_steps_q;
	logic [hes_pkg::STEPS_W-1:0] steps_done_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] emit_q;
	logic m_tvalid_q;
	logic m_tlast_q;
	logic signed [hes_pkg::SAMPLE_W-1:0] m_value_q;

	logic load_beat;
	logic run_step;
	logic out_load;
	logic signed [hes_pkg::SAMPLE_W-1:0] load_val;
	logic signed [hes_pkg::SAMPLE_W-1:0] cell_val [GRID_POINTS];
	hes_pkg::cell_ctrl_t inner_ctrl;
	hes_pkg::cell_ctrl_t edge_ctrl;

	// Handshake and control decode
	assign s_tready  = (state_q == hes_pkg::ST_LOAD);
	assign load_beat = s_tvalid && s_tready;
	assign run_step  = (state_q == hes_pkg::ST_RUN) && (steps_done_q != run_steps_q);
	assign out_load  = (state_q == hes_pkg::ST_EMIT) && (!m_tvalid_q || m_tready);

	// End points are stored as zero whatever sample arrives
	assign load_val = ((pos_q == '0) || (pos_q == LAST_IDX)) ? '0 : $signed(s_tdata);

	assign inner_ctrl.shift = load_beat || out_load;
	assign inner_ctrl.step  = run_step;
	assign edge_ctrl.shift  = load_beat || out_load;
	assign edge_ctrl.step   = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= 16'd16384;
			step_count_q <= 16'd953;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hes_pkg::REG_ALPHA: alpha_q      <= cfg_data;
				hes_pkg::REG_STEPS: step_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: load, run the time steps, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hes_pkg::ST_LOAD;
			pos_q        <= '0;
			emit_q       <= '0;
			steps_done_q <= '0;
			run_alpha_q  <= '0;
			run_steps_q  <= '0;
		end else begin
			unique case (state_q)
				hes_pkg::ST_LOAD: begin
					if (load_beat) begin
						if (pos_q == LAST_IDX) begin
							pos_q        <= '0;
							run_alpha_q  <= alpha_q;
							run_steps_q  <= step_count_q;
							steps_done_q <= '0;
							state_q      <= hes_pkg::ST_RUN;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				hes_pkg::ST_RUN: begin
					if (run_step) begin
						steps_done_q <= steps_done_q + 1'b1;
					end else begin
						emit_q  <= '0;
						state_q <= hes_pkg::ST_EMIT;
					end
				end
				hes_pkg::ST_EMIT: begin
					if (out_load) begin
						if (emit_q == LAST_IDX) begin
							emit_q  <= '0;
							state_q <= hes_pkg::ST_LOAD;
						end else begin
							emit_q <= emit_q + 1'b1;
						end
					end
				end
				default: state_q <= hes_pkg::ST_LOAD;
			endcase
		end
	end

	// Output register: hold a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
			m_tlast_q  <= (emit_q == LAST_IDX);
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_value_q <= cell_val[0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_value_q;
	assign m_tlast  = m_tlast_q;

	// Row of cells; data moves toward cell 0, new samples enter at the far end
	for (genvar i = 0; i < GRID_POINTS; i++) begin : g_cell
		logic signed [hes_pkg::SAMPLE_W-1:0] left_val;
		logic signed [hes_pkg::SAMPLE_W-1:0] right_val;
		hes_pkg::cell_ctrl_t ctrl;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end

		if (i == GRID_POINTS - 1) begin : g_last
			assign right_val = load_beat ? load_val : '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end

		if ((i == 0) || (i == GRID_POINTS - 1)) begin : g_edge
			assign ctrl = edge_ctrl;
		end else begin : g_inner
			assign ctrl = inner_ctrl;
		end

		hes_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.alpha (run_alpha_q),
			.left  (left_val),
			.right (right_val),
			.value (cell_val[i])
		);
	end

	// The flagged beat is the final one, so the sequencer is back in load
	a_last_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && !$past(m_tvalid && m_tlast)) |-> (state_q == hes_pkg::ST_LOAD))
		else $error("last beat shown outside load state");

	// Boundary cells stay at zero while the steps run
	a_edges_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hes_pkg::ST_RUN) |->
			(cell_val[0] == '0) && (cell_val[GRID_POINTS-1] == '0))
		else $error("boundary cell not zero during run");

	// Step counter never passes the requested count
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hes_pkg::ST_RUN) |-> (steps_done_q <= run_steps_q))
		else $error("step counter overran");

	// No output beat is loaded while samples are being taken
	a_no_emit_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_beat |-> !out_load)
		else $error("load and emit overlap");

endmodule

/* verif/tb_heat_equation_stencil_1d.sv */
// Self-checking bench for heat_equation_stencil_1d: streams grids of Q1.14 samples,
// mirrors the FTCS time steps in a behavioral predictor and checks every emitted beat.
// Depends on hes_pkg and the heat_equation_stencil_1d RTL.
module tb_heat_equation_stencil_1d;

	localparam int GRID_POINTS   = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 200;

	typedef enum int {
		GRID_RANDOM,
		GRID_EXTREME,
		GRID_SMOOTH
	} grid_kind_t;

	typedef struct packed {
		logic signed [hes_pkg::SAMPLE_W-1:0] value;
		logic                                last;
	} temp_beat_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [hes_pkg::CFG_IDX_W-1:0] cfg_index = hes_pkg::REG_ALPHA;
	logic [hes_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata   = '0;   // [15:0] sample
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [15:0]                   m_tdata;          // [15:0] value
	logic                          m_tlast;          // last_value

	// Predictor state: the grid being loaded and a copy of both registers
	logic signed [hes_pkg::SAMPLE_W-1:0] load_grid [GRID_POINTS];
	int                                  fill_pos      = 0;
	logic [hes_pkg::ALPHA_W-1:0]         alpha_mirror  = 16'd16384;
	logic [hes_pkg::STEPS_W-1:0]         steps_mirror  = 16'd953;
	temp_beat_t                          final_temps_q [$];
	logic [15:0]                         sample_q      [$];

	int items_pushed   = 0;
	int items_accepted = 0;
	int temps_due      = 0;
	int grids_done     = 0;
	int values_checked = 0;
	int errors         = 0;
	int send_wait      = 0;
	int recv_wait      = 0;
	int hold_left      = 0;
	bit hold_armed     = 1'b0;
	bit send_steady    = 1'b0;
	bit recv_steady    = 1'b0;
	bit in_taken       = 1'b0;
	bit out_taken      = 1'b0;

	heat_equation_stencil_1d #(
		.GRID_POINTS(GRID_POINTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// One interior point: round the Q.30 sum to nearest (ties up), then saturate
	function automatic logic signed [hes_pkg::SAMPLE_W-1:0] ftcs_point(
		input logic signed [hes_pkg::SAMPLE_W-1:0] left,
		input logic signed [hes_pkg::SAMPLE_W-1:0] mid,
		input logic signed [hes_pkg::SAMPLE_W-1:0] right,
		input logic [hes_pkg::ALPHA_W-1:0]         a
	);
		longint al;
		longint w;
		longint s;
		longint q;
		al = a;
		w  = 65536 - 2 * al;
		s  = al * (longint'(left) + longint'(right)) + w * longint'(mid);
		q  = (s + 32768) >>> 16;
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	// Store one loaded sample; on a full grid run all time steps and queue the final grid
	function automatic void absorb_sample(input logic signed [hes_pkg::SAMPLE_W-1:0] raw);
		logic signed [hes_pkg::SAMPLE_W-1:0] cur [GRID_POINTS];
		logic signed [hes_pkg::SAMPLE_W-1:0] nxt [GRID_POINTS];
		temp_beat_t beat;
		// End points follow the Dirichlet condition whatever was sent
		load_grid[fill_pos] = (fill_pos == 0 || fill_pos == GRID_POINTS - 1) ? '0 : raw;
		fill_pos++;
		if (fill_pos == GRID_POINTS) begin
			fill_pos = 0;
			cur = load_grid;
			for (int n = 0; n < steps_mirror; n++) begin
				nxt[0] = '0;
				nxt[GRID_POINTS-1] = '0;
				for (int i = 1; i < GRID_POINTS - 1; i++)
					nxt[i] = ftcs_point(cur[i-1], cur[i], cur[i+1], alpha_mirror);
				cur = nxt;
			end
			for (int i = 0; i < GRID_POINTS; i++) begin
				beat.value = cur[i];
				beat.last  = (i == GRID_POINTS - 1);
				final_temps_q.push_back(beat);
			end
			temps_due += GRID_POINTS;
			grids_done++;
		end
	endfunction

	// Mostly no gap, often a short one, now and then a long one
	function automatic int idle_len(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_sample(input grid_kind_t kind, input int idx);
		int v;
		case (kind)
			GRID_EXTREME: begin
				if ($urandom_range(0, 3) == 0)
					v = 0;
				else
					v = idx[0] ? 32767 : -32768;
			end
			GRID_SMOOTH: begin
				v = int'($urandom_range(0, 16383)) - 8192;
			end
			default: begin
				v = $urandom_range(0, 65535);
			end
		endcase
		return v[15:0];
	endfunction

	// Sample side: accept beats and feed the predictor; result side: compare beats
	always @(posedge clk) begin
		temp_beat_t want;
		in_taken  = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (in_taken) begin
			items_accepted++;
			absorb_sample(s_tdata);
		end
		if (out_taken) begin
			values_checked++;
			if (final_temps_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got value %0d last %0b",
					$time, $signed(m_tdata), m_tlast);
			end else begin
				want = final_temps_q.pop_front();
				temps_due--;
				if (m_tdata !== want.value) begin
					errors++;
					$display("%0t: value mismatch, expected %0d, got %0d", $time,
						want.value, $signed(m_tdata));
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: last flag mismatch, expected %0b, got %0b", $time,
						want.last, m_tlast);
				end
			end
		end
	end

	// Sample driver: hold a beat until taken, then idle before the next one
	always @(negedge clk) begin
		logic        next_valid;
		logic [15:0] next_data;
		next_valid = s_tvalid;
		next_data  = s_tdata;
		if (in_taken)
			next_valid = 1'b0;
		if (!next_valid) begin
			if (send_wait > 0) begin
				send_wait--;
			end else if (sample_q.size() != 0) begin
				next_data  = sample_q.pop_front();
				next_valid = 1'b1;
				send_wait  = idle_len(send_steady);
			end
		end
		s_tvalid <= next_valid;
		s_tdata  <= next_data;
	end

	// Result receiver: random stalls, plus one long hold once armed
	always @(negedge clk) begin
		logic next_ready;
		next_ready = 1'b0;
		if (out_taken)
			recv_wait = idle_len(recv_steady);
		if (!arst_n) begin
			next_ready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end else if (hold_armed && m_tvalid) begin
			hold_armed = 1'b0;
			hold_left  = HOLD_CYCLES - 1;
		end else if (recv_wait > 0) begin
			recv_wait--;
		end else begin
			next_ready = 1'b1;
		end
		m_tready <= next_ready;
	end

	task automatic write_reg(input logic [hes_pkg::CFG_IDX_W-1:0] idx,
		input logic [hes_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == hes_pkg::REG_ALPHA)
			alpha_mirror = val;
		else
			steps_mirror = val;
	endtask

	task automatic push_samples(input grid_kind_t kind, input int n);
		for (int i = 0; i < n; i++) begin
			sample_q.push_back(pick_sample(kind, i));
			items_pushed++;
		end
	endtask

	task automatic wait_idle();
		wait (items_accepted == items_pushed && temps_due == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic shuffle_pacing();
		send_steady = ($urandom_range(0, 3) == 0);
		recv_steady = ($urandom_range(0, 3) == 0);
	endtask

	// Stimulus: directed grid at reset settings, then grids under several register settings
	initial begin
		logic [15:0] edge_samples [0:23];
		logic [15:0] a_pick;
		edge_samples = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000,
			16'hFFFF, 16'h0001, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h4000, 16'hC000, 16'h5555, 16'hAAAA, 16'h0002, 16'hFFFE,
			16'h2000, 16'hE000, 16'h7FFE, 16'h8001, 16'h0000, 16'h0000};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset register values; extremes, with nonzero samples on both end points
		shuffle_pacing();
		for (int i = 0; i < 24; i++) begin
			sample_q.push_back(edge_samples[i]);
			items_pushed++;
		end
		push_samples(GRID_RANDOM, GRID_POINTS - 25);
		sample_q.push_back(16'h8000);
		items_pushed++;

		// Full-scale alpha: negative center weight, saturation on alternating extremes
		wait_idle();
		shuffle_pacing();
		write_reg(hes_pkg::REG_ALPHA, 16'hFFFF);
		write_reg(hes_pkg::REG_STEPS, 16'd4);
		push_samples(GRID_EXTREME, GRID_POINTS);

		// Zero alpha leaves the grid as loaded
		wait_idle();
		shuffle_pacing();
		write_reg(hes_pkg::REG_ALPHA, 16'd0);
		write_reg(hes_pkg::REG_STEPS, 16'd12);
		push_samples(GRID_RANDOM, GRID_POINTS);

		// Alpha at one half over the longest run
		wait_idle();
		shuffle_pacing();
		write_reg(hes_pkg::REG_ALPHA, 16'd32768);
		write_reg(hes_pkg::REG_STEPS, 16'hFFFF);
		push_samples(GRID_SMOOTH, GRID_POINTS);

		// Registers rewritten partway through a load; zero steps
		wait_idle();
		shuffle_pacing();
		write_reg(hes_pkg::REG_ALPHA, 16'd1);
		write_reg(hes_pkg::REG_STEPS, 16'd1);
		push_samples(GRID_RANDOM, 30);
		wait_idle();
		write_reg(hes_pkg::REG_ALPHA, 16'($urandom_range(0, 32768)));
		write_reg(hes_pkg::REG_STEPS, 16'd0);
		push_samples(GRID_RANDOM, GRID_POINTS - 30);

		// Two grids back to back with a long output hold so the input backs up
		wait_idle();
		shuffle_pacing();
		if ($urandom_range(0, 99) < 85)
			a_pick = 16'($urandom_range(0, 32768));
		else
			a_pick = 16'($urandom_range(32769, 65535));
		write_reg(hes_pkg::REG_ALPHA, a_pick);
		write_reg(hes_pkg::REG_STEPS, 16'($urandom_range(1, 300)));
		hold_armed = 1'b1;
		push_samples(GRID_RANDOM, GRID_POINTS);
		push_samples(GRID_SMOOTH, GRID_POINTS);

		// A partial load at the end gives no results
		wait_idle();
		push_samples(GRID_RANDOM, 22);

		wait (items_accepted == items_pushed && temps_due == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Run covered %0d grids and %0d checked values from %0d accepted samples.",
			grids_done, values_checked, items_accepted);
		$display("Alpha spanned zero, one half and full scale; step counts spanned 0 to 65535.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog far beyond the slowest legal run
	initial begin
		#6000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
